[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the batch levelizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/abl_pkg.sv]
// Package of the batch levelizer: sizes, limits, sequencer states and helpers.
package abl_pkg;

   localparam int MAX_NODES   = 256;   // power of two; ids index it modulo its size
   localparam int MAX_FANIN   = 4;
   localparam int GRADE_BITS  = 16;

   localparam int ID_W        = 8;
   localparam int MASK_W      = 16;
   localparam int CNT_IN_W    = 3;
   localparam int LEVEL_W     = 8;
   localparam int TOTAL_W     = 9;
   localparam int FIELD_PORTS = 4;

   localparam int FANIN_LIMIT = (MAX_FANIN < FIELD_PORTS) ? MAX_FANIN : FIELD_PORTS;
   localparam int NODE_AW     = $clog2(MAX_NODES);
   localparam int PORT_SEL_W  = $clog2(FIELD_PORTS);

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
   localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;
   localparam logic [MASK_W-1:0]  GRADE_KEEP =
      (GRADE_BITS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << GRADE_BITS) - 64'd1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MASK,
      ST_FINISH
   } abl_state_type;

   // Table slot of a node id or batch index (modulo the table size).
   function automatic logic [NODE_AW-1:0] slot_of(input logic [ID_W-1:0] id);
      return NODE_AW'(id);
   endfunction

   // Next batch after a producer's batch, held at the top batch.
   function automatic logic [LEVEL_W-1:0] sat_inc(input logic [LEVEL_W-1:0] level);
      return (level == LEVEL_MAX) ? level : level + LEVEL_W'(1);
   endfunction

endpackage

[rtl/abl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module abl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/asap_batch_levelizer_unit.sv]
// Top level of the batch levelizer: ASAP batch assignment of graph nodes.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  req_    | in        | req_valid/req_stall  | node id, grade mask, fan-in ids, last flag
//  rsp_    | out       | rsp_valid/rsp_stall  | node, batch, batch mask, totals, done flag
//
// A request steps through an accept state, one level-table read per producer id (up to
// its clamped input count) through the single read port of the level RAM, the batch-mask
// read, and a write-back that also loads the response register.
// Reset clears the sequencer, the placed bits and both counters at once; the RAMs
// need no clearing pass. The block takes a new request while a response still waits,
// and holds the write-back cycle only while the response register is full and stalled.
module asap_batch_levelizer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [abl_pkg::ID_W-1:0]      req_node_id,
   input  logic [abl_pkg::MASK_W-1:0]    req_grade_mask,
   input  logic [abl_pkg::CNT_IN_W-1:0]  req_input_count,
   input  logic [abl_pkg::ID_W-1:0]      req_input_a,
   input  logic [abl_pkg::ID_W-1:0]      req_input_b,
   input  logic [abl_pkg::ID_W-1:0]      req_input_c,
   input  logic [abl_pkg::ID_W-1:0]      req_input_d,
   input  logic                          req_last_node,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [abl_pkg::ID_W-1:0]      rsp_placed_node,
   output logic [abl_pkg::LEVEL_W-1:0]   rsp_batch_index,
   output logic [abl_pkg::MASK_W-1:0]    rsp_batch_mask,
   output logic [abl_pkg::TOTAL_W-1:0]   rsp_batch_total,
   output logic [abl_pkg::TOTAL_W-1:0]   rsp_node_total,
   output logic                          rsp_plan_done
);
   import abl_pkg::*;

   // Sequencer state and captured request.
   abl_state_type          state_ff, state_in;
   logic [ID_W-1:0]        node_ff, node_in;
   logic [MASK_W-1:0]      gmask_ff, gmask_in;
   logic [ID_W-1:0]        ids_ff [FIELD_PORTS];
   logic [ID_W-1:0]        ids_in [FIELD_PORTS];
   logic [CNT_IN_W-1:0]    cnt_ff, cnt_in;
   logic                   last_ff, last_in;

   // Shared max unit state.
   logic [CNT_IN_W-1:0]    idx_ff, idx_in;
   logic                   pend_ff, pend_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic                   open_ff, open_in;

   // Graph state.
   logic [MAX_NODES-1:0]   placed_ff, placed_in;
   logic [TOTAL_W-1:0]     batch_cnt_ff, batch_cnt_in;
   logic [TOTAL_W-1:0]     node_cnt_ff, node_cnt_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]        rsp_node_ff, rsp_node_in;
   logic [LEVEL_W-1:0]     rsp_level_ff, rsp_level_in;
   logic [MASK_W-1:0]      rsp_mask_ff, rsp_mask_in;
   logic [TOTAL_W-1:0]     rsp_btot_ff, rsp_btot_in;
   logic [TOTAL_W-1:0]     rsp_ntot_ff, rsp_ntot_in;
   logic                   rsp_done_ff, rsp_done_in;

   // RAM ports.
   logic                   lvl_we;
   logic [NODE_AW-1:0]     lvl_waddr, lvl_raddr;
   logic [LEVEL_W-1:0]     lvl_wdata, lvl_rdata;
   logic                   msk_we;
   logic [NODE_AW-1:0]     msk_waddr, msk_raddr;
   logic [MASK_W-1:0]      msk_wdata, msk_rdata;

   logic                   req_accept;
   logic                   out_free;
   logic                   finish_go;
   logic [CNT_IN_W-1:0]    req_cnt_clamp;
   logic [LEVEL_W-1:0]     cand;
   logic [LEVEL_W-1:0]     level_acc;
   logic [ID_W-1:0]        fetch_id;
   logic [MASK_W-1:0]      mask_new;

   abl_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_NODES)) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (lvl_waddr),
      .wr_data (lvl_wdata),
      .rd_addr (lvl_raddr),
      .rd_data (lvl_rdata)
   );

   abl_ram #(.WIDTH(MASK_W), .DEPTH(MAX_NODES)) u_mask_ram (
      .clock   (clock),
      .wr_en   (msk_we),
      .wr_addr (msk_waddr),
      .wr_data (msk_wdata),
      .rd_addr (msk_raddr),
      .rd_data (msk_rdata)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish_go  = (state_ff == ST_FINISH) && out_free;

   // Fan-in counts beyond the supported ports act as the largest supported count.
   assign req_cnt_clamp = (req_input_count > CNT_IN_W'(FANIN_LIMIT)) ?
                          CNT_IN_W'(FANIN_LIMIT) : req_input_count;

   // Shared max unit: fold the level read issued last cycle into the running max,
   // but only if that producer was placed when the read went out.
   assign cand      = sat_inc(lvl_rdata);
   assign level_acc = (pend_ff && (cand > level_ff)) ? cand : level_ff;

   assign fetch_id  = ids_ff[idx_ff[PORT_SEL_W-1:0]];

   // A freshly opened batch starts from an empty mask.
   assign mask_new  = (open_ff ? '0 : msk_rdata) | gmask_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_cnt_clamp == '0) ? ST_MASK : ST_FETCH;
            end
         end
         ST_FETCH: begin
            if ((idx_ff + CNT_IN_W'(1)) == cnt_ff) begin
               state_in = ST_MASK;
            end
         end
         ST_MASK: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and RAM control per state.
   always_comb begin
      node_in      = node_ff;
      gmask_in     = gmask_ff;
      ids_in       = ids_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      level_in     = level_ff;
      open_in      = open_ff;
      placed_in    = placed_ff;
      batch_cnt_in = batch_cnt_ff;
      node_cnt_in  = node_cnt_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_node_in  = rsp_node_ff;
      rsp_level_in = rsp_level_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_btot_in  = rsp_btot_ff;
      rsp_ntot_in  = rsp_ntot_ff;
      rsp_done_in  = rsp_done_ff;

      lvl_we    = 1'b0;
      lvl_waddr = slot_of(node_ff);
      lvl_wdata = level_ff;
      lvl_raddr = slot_of(fetch_id);
      msk_we    = 1'b0;
      msk_waddr = slot_of(level_ff);
      msk_wdata = mask_new;
      msk_raddr = slot_of(level_acc);

      case (state_ff)
         ST_IDLE: begin
            // Capture the request and reset the running max.
            if (req_accept) begin
               node_in  = req_node_id;
               gmask_in = req_grade_mask & GRADE_KEEP;
               ids_in[0] = req_input_a;
               ids_in[1] = req_input_b;
               ids_in[2] = req_input_c;
               ids_in[3] = req_input_d;
               cnt_in   = req_cnt_clamp;
               last_in  = req_last_node;
            end
            idx_in   = '0;
            pend_in  = 1'b0;
            level_in = '0;
         end
         ST_FETCH: begin
            // Issue one producer read and fold the previous one.
            level_in = level_acc;
            pend_in  = placed_ff[slot_of(fetch_id)];
            idx_in   = idx_ff + CNT_IN_W'(1);
         end
         ST_MASK: begin
            // Fold the last producer and read the chosen batch's mask.
            level_in = level_acc;
            pend_in  = 1'b0;
            open_in  = ({1'b0, level_acc} == batch_cnt_ff);
         end
         ST_FINISH: begin
            if (out_free) begin
               lvl_we = 1'b1;
               msk_we = 1'b1;

               rsp_valid_in = 1'b1;
               rsp_node_in  = node_ff;
               rsp_level_in = level_ff;
               rsp_mask_in  = mask_new;
               rsp_btot_in  = open_ff ? batch_cnt_ff + TOTAL_W'(1) : batch_cnt_ff;
               rsp_ntot_in  = (node_cnt_ff == COUNT_MAX) ? node_cnt_ff :
                              node_cnt_ff + TOTAL_W'(1);
               rsp_done_in  = last_ff;

               if (last_ff) begin
                  // Drop the whole graph after its final node.
                  placed_in    = '0;
                  batch_cnt_in = '0;
                  node_cnt_in  = '0;
               end else begin
                  placed_in[slot_of(node_ff)] = 1'b1;
                  batch_cnt_in = rsp_btot_in;
                  node_cnt_in  = rsp_ntot_in;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         placed_ff    <= '0;
         batch_cnt_ff <= '0;
         node_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         placed_ff    <= placed_in;
         batch_cnt_ff <= batch_cnt_in;
         node_cnt_ff  <= node_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      gmask_ff     <= gmask_in;
      ids_ff       <= ids_in;
      cnt_ff       <= cnt_in;
      last_ff      <= last_in;
      level_ff     <= level_in;
      open_ff      <= open_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_level_ff <= rsp_level_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_btot_ff  <= rsp_btot_in;
      rsp_ntot_ff  <= rsp_ntot_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_placed_node = rsp_node_ff;
   assign rsp_batch_index = rsp_level_ff;
   assign rsp_batch_mask  = rsp_mask_ff;
   assign rsp_batch_total = rsp_btot_ff;
   assign rsp_node_total  = rsp_ntot_ff;
   assign rsp_plan_done   = rsp_done_ff;

`include "assert_macros.svh"

   // A placed node always sits in an opened batch, so the running max never
   // passes the batch count.
   `ASSERT_IMPLY(a_level_bounded, clock, reset, state_ff != ST_IDLE, {1'b0, level_ff} <= batch_cnt_ff, "running batch beyond opened batches")

   // A new response only appears from the write-back cycle.
   `ASSERT_IMPLY(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH, "response loaded outside write-back")

   // Every reported batch lies below the reported batch count.
   `ASSERT_IMPLY(a_rsp_index_in_range, clock, reset, rsp_valid_ff, {1'b0, rsp_level_ff} < rsp_btot_ff, "batch index not below batch total")

   // After the last node all graph state is gone.
   `ASSERT_NEXT(a_clear_after_last, clock, reset, finish_go && last_ff, (batch_cnt_ff == '0) && (node_cnt_ff == '0) && (placed_ff == '0), "graph state not cleared after last node")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the ASAP batch levelizer: directed, overflow, backpressure
// and random graph tests.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import abl_pkg::*;

   // One expected response: everything the block reports for a placed node.
   typedef struct packed {
      logic [ID_W-1:0]    node;
      logic [LEVEL_W-1:0] batch;
      logic [MASK_W-1:0]  mask;
      logic [TOTAL_W-1:0] batch_total;
      logic [TOTAL_W-1:0] node_total;
      logic               done;
   } placement_type;

   localparam int NODE_SAT  = 511;   // node_total holds here
   localparam int HOLD_LONG = 300;   // receiver hold-off, in cycles

   // Clock and reset. Reset is synchronous and starts asserted.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request side, driven to known values from time zero.
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [ID_W-1:0]     req_node_id     = '0;
   logic [MASK_W-1:0]   req_grade_mask  = '0;
   logic [CNT_IN_W-1:0] req_input_count = '0;
   logic [ID_W-1:0]     req_input_a     = '0;
   logic [ID_W-1:0]     req_input_b     = '0;
   logic [ID_W-1:0]     req_input_c     = '0;
   logic [ID_W-1:0]     req_input_d     = '0;
   logic                req_last_node   = 1'b0;

   // Response side.
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ID_W-1:0]     rsp_placed_node;
   logic [LEVEL_W-1:0]  rsp_batch_index;
   logic [MASK_W-1:0]   rsp_batch_mask;
   logic [TOTAL_W-1:0]  rsp_batch_total;
   logic [TOTAL_W-1:0]  rsp_node_total;
   logic                rsp_plan_done;

   // Shadow of the block's plan state, kept by place_node().
   bit                 placed_shadow [MAX_NODES];
   logic [LEVEL_W-1:0] level_shadow  [MAX_NODES];
   logic [MASK_W-1:0]  batch_or      [MAX_NODES];
   int                 batches_open;
   int                 nodes_in_plan;

   placement_type pending_placements [$];

   // Run bookkeeping.
   int mismatches     = 0;
   int nodes_sent     = 0;
   int graphs_planned = 0;
   int responses_seen = 0;

   // Idling controls: quiet flags switch random gaps off, hold_request asks for a long
   // receiver hold-off that the stall process counts down on its own.
   bit req_quiet    = 1'b0;
   bit rsp_quiet    = 1'b0;
   int hold_request = 0;

   asap_batch_levelizer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_node_id     (req_node_id),
      .req_grade_mask  (req_grade_mask),
      .req_input_count (req_input_count),
      .req_input_a     (req_input_a),
      .req_input_b     (req_input_b),
      .req_input_c     (req_input_c),
      .req_input_d     (req_input_d),
      .req_last_node   (req_last_node),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_placed_node (rsp_placed_node),
      .rsp_batch_index (rsp_batch_index),
      .rsp_batch_mask  (rsp_batch_mask),
      .rsp_batch_total (rsp_batch_total),
      .rsp_node_total  (rsp_node_total),
      .rsp_plan_done   (rsp_plan_done)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Drop the whole plan back to its reset state: placed bits, counters, masks.
   function automatic void clear_plan();
      for (int s = 0; s < MAX_NODES; s++) begin
         placed_shadow[s] = 1'b0;
         level_shadow[s]  = '0;
         batch_or[s]      = '0;
      end
      batches_open  = 0;
      nodes_in_plan = 0;
   endfunction

   // Place one node ASAP and return the response the block must give for it.
   // Only the first input_count producers count (capped at the fan-in limit);
   // producers without a placed bit are ignored, which also covers a node naming
   // itself before its first placement.
   function automatic placement_type place_node(input logic [ID_W-1:0]     id,
                                                input logic [MASK_W-1:0]   gmask,
                                                input logic [CNT_IN_W-1:0] cnt,
                                                input logic [ID_W-1:0]     a,
                                                input logic [ID_W-1:0]     b,
                                                input logic [ID_W-1:0]     c,
                                                input logic [ID_W-1:0]     d,
                                                input logic                last);
      logic [ID_W-1:0] producers [FIELD_PORTS];
      int              used;
      int              lvl;
      int              cand;
      placement_type   r;
      producers[0] = a;
      producers[1] = b;
      producers[2] = c;
      producers[3] = d;
      used = (int'(cnt) > FANIN_LIMIT) ? FANIN_LIMIT : int'(cnt);
      lvl  = 0;
      for (int i = 0; i < used; i++) begin
         if (placed_shadow[producers[i] % MAX_NODES]) begin
            cand = int'(level_shadow[producers[i] % MAX_NODES]) + 1;
            if (cand > int'(LEVEL_MAX)) cand = int'(LEVEL_MAX);
            if (cand > lvl) lvl = cand;
         end
      end
      // A repeated node simply takes its new batch; its old batch keeps its mask.
      level_shadow[id % MAX_NODES]  = LEVEL_W'(lvl);
      placed_shadow[id % MAX_NODES] = 1'b1;
      // Open every batch up to this one with an empty mask.
      while (batches_open <= lvl) begin
         batch_or[batches_open % MAX_NODES] = '0;
         batches_open++;
      end
      batch_or[lvl % MAX_NODES] = batch_or[lvl % MAX_NODES] | (gmask & GRADE_KEEP);
      if (nodes_in_plan < NODE_SAT) nodes_in_plan++;
      r.node        = id;
      r.batch       = LEVEL_W'(lvl);
      r.mask        = batch_or[lvl % MAX_NODES];
      r.batch_total = TOTAL_W'(batches_open);
      r.node_total  = TOTAL_W'(nodes_in_plan);
      r.done        = last;
      if (last) begin
         clear_plan();
         graphs_planned++;
      end
      return r;
   endfunction

   // Offer one request, maybe after a random gap, and hold it until accepted.
   // The expectation is queued at the accepting edge, so the queue follows
   // acceptance order exactly.
   task automatic send_node(input logic [ID_W-1:0]     id,
                            input logic [MASK_W-1:0]   gmask,
                            input logic [CNT_IN_W-1:0] cnt,
                            input logic [ID_W-1:0]     a,
                            input logic [ID_W-1:0]     b,
                            input logic [ID_W-1:0]     c,
                            input logic [ID_W-1:0]     d,
                            input logic                last);
      if (!req_quiet && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_node_id     <= id;
      req_grade_mask  <= gmask;
      req_input_count <= cnt;
      req_input_a     <= a;
      req_input_b     <= b;
      req_input_c     <= c;
      req_input_d     <= d;
      req_last_node   <= last;
      do @(posedge clock); while (req_stall);
      pending_placements.insert(pending_placements.size(),
                                place_node(id, gmask, cnt, a, b, c, d, last));
      nodes_sent++;
   endtask

   // Receiver: random stalls, none while quiet, and a counted hold-off on request.
   initial begin : stall_driver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !rsp_quiet && ($urandom_range(99) < 14);
         end
      end
   end

   function automatic void check_field(input string name, input logic [MASK_W-1:0] want,
                                       input logic [MASK_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted response against the oldest expectation.
   always @(posedge clock) begin : response_check
      placement_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         responses_seen++;
         if (pending_placements.size() == 0) begin
            $display("%0t ns: response with no request pending, expected none, actual node %0h",
                     $time, rsp_placed_node);
            mismatches++;
         end else begin
            want = pending_placements.pop_front();
            check_field("placed_node", MASK_W'(want.node),        MASK_W'(rsp_placed_node));
            check_field("batch_index", MASK_W'(want.batch),       MASK_W'(rsp_batch_index));
            check_field("batch_mask",  want.mask,                 rsp_batch_mask);
            check_field("batch_total", MASK_W'(want.batch_total), MASK_W'(rsp_batch_total));
            check_field("node_total",  MASK_W'(want.node_total),  MASK_W'(rsp_node_total));
            check_field("plan_done",   MASK_W'(want.done),        MASK_W'(rsp_plan_done));
         end
      end
   end

   // Directed: field extremes, fan-in handling, repeats, self references, last flag.
   task automatic test_directed();
      // A graph of a single node: batch 0, empty mask, done at once.
      send_node(8'd0,   16'h0000, 3'd0, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
      // Source node with the top id and a full mask.
      send_node(8'd255, 16'hFFFF, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_node(8'd10,  16'h0001, 3'd1, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
      // One placed producer, one never placed: the unplaced one is ignored.
      send_node(8'd11,  16'h8000, 3'd2, 8'd10,  8'd200, 8'd0,   8'd0,   1'b0);
      // Full fan-in, last slot naming the node itself before it is placed.
      send_node(8'd12,  16'h5555, 3'd4, 8'd255, 8'd10,  8'd11,  8'd12,  1'b0);
      // Counts above the fan-in limit fall back to four producers.
      send_node(8'd13,  16'hAAAA, 3'd7, 8'd0,   8'd0,   8'd0,   8'd11,  1'b0);
      send_node(8'd14,  16'h00F0, 3'd5, 8'd13,  8'd85,  8'd170, 8'd0,   1'b0);
      send_node(8'd15,  16'h0F00, 3'd6, 8'd128, 8'd1,   8'd2,   8'd3,   1'b0);
      // Node 12 again, naming itself: uses its earlier batch and moves up one.
      send_node(8'd12,  16'h0002, 3'd1, 8'd12,  8'd0,   8'd0,   8'd0,   1'b0);
      // Count of three: the placed producer in slot d must not count.
      send_node(8'd20,  16'h0004, 3'd3, 8'd12,  8'd0,   8'd1,   8'd12,  1'b0);
      send_node(8'd21,  16'h0008, 3'd3, 8'd0,   8'd0,   8'd0,   8'd20,  1'b0);
      // Back into batch 0, ORing into an existing batch mask.
      send_node(8'd170, 16'h1234, 3'd0, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
      send_node(8'd85,  16'hFFFF, 3'd2, 8'd170, 8'd255, 8'd0,   8'd0,   1'b0);
      send_node(8'd128, 16'h8001, 3'd4, 8'd20,  8'd21,  8'd85,  8'd12,  1'b1);
      // After the last node nothing is placed any more: this lands in batch 0.
      send_node(8'd10,  16'h0010, 3'd1, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
      send_node(8'd1,   16'h0020, 3'd2, 8'd10,  8'd10,  8'd0,   8'd0,   1'b1);
   endtask

   // A chain longer than the table: batches saturate at the top, ids wrap and are
   // placed more than once, and the node total saturates before the last node.
   task automatic test_chain_overflow();
      for (int k = 0; k < 520; k++) begin
         send_node(ID_W'(k), MASK_W'(1 << (k % MASK_W)), (k == 0) ? 3'd0 : 3'd1,
                   ID_W'(k - 1), ID_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                   k == 519);
      end
   endtask

   // Hold the receiver off for a long stretch while requests keep coming, so the
   // block fills and pushes back on its input.
   task automatic test_backpressure();
      req_quiet    = 1'b1;
      hold_request = HOLD_LONG;
      for (int k = 0; k < 40; k++) begin
         send_node(ID_W'(k + 40), MASK_W'($urandom), 3'($urandom_range(0, 4)),
                   ID_W'(k + 39), ID_W'(k + 30), ID_W'($urandom_range(40, 79)),
                   ID_W'($urandom), k == 39);
      end
      req_quiet = 1'b0;
   endtask

   // Random graphs: mostly well-formed (producers drawn from nodes already in the
   // graph, recent ones favored for depth), with some noise ids and oversized counts.
   task automatic test_random_graphs(input int target);
      logic [ID_W-1:0]     in_graph [$];
      logic [ID_W-1:0]     srcs [FIELD_PORTS];
      logic [ID_W-1:0]     id;
      logic [MASK_W-1:0]   gmask;
      logic [CNT_IN_W-1:0] cnt;
      int                  size;
      int                  roll;
      int                  graph_no;
      graph_no = 0;
      while (nodes_sent < target) begin
         roll = $urandom_range(99);
         if (roll < 5)       size = 1;
         else if (roll < 75) size = $urandom_range(2, 30);
         else                size = $urandom_range(31, 120);
         if (size > target - nodes_sent) size = target - nodes_sent;
         // A run of graphs with no gaps on either side.
         req_quiet = (graph_no >= 8 && graph_no < 13);
         rsp_quiet = req_quiet;
         in_graph.delete();
         for (int k = 0; k < size; k++) begin
            if (in_graph.size() > 0 && $urandom_range(99) < 10)
               id = in_graph[$urandom_range(in_graph.size() - 1)];
            else
               id = ID_W'($urandom);
            for (int j = 0; j < FIELD_PORTS; j++) begin
               roll = $urandom_range(99);
               if (in_graph.size() > 0 && roll < 50)
                  srcs[j] = in_graph[in_graph.size() - 1 -
                                     $urandom_range((in_graph.size() > 4) ? 3 :
                                                    in_graph.size() - 1)];
               else if (in_graph.size() > 0 && roll < 85)
                  srcs[j] = in_graph[$urandom_range(in_graph.size() - 1)];
               else
                  srcs[j] = ID_W'($urandom);
            end
            cnt  = ($urandom_range(99) < 10) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            roll = $urandom_range(99);
            if (roll < 8)       gmask = '0;
            else if (roll < 16) gmask = '1;
            else if (roll < 30) gmask = MASK_W'(1 << $urandom_range(MASK_W - 1));
            else                gmask = MASK_W'($urandom);
            send_node(id, gmask, cnt, srcs[0], srcs[1], srcs[2], srcs[3], k == size - 1);
            in_graph.insert(in_graph.size(), id);
         end
         graph_no++;
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   initial begin : run_tests
      int drain;
      clear_plan();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_chain_overflow();
      test_backpressure();
      test_random_graphs(1950);
      req_valid <= 1'b0;

      // Drain: wait for every expected response, then keep watching for strays.
      drain = 0;
      while (pending_placements.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (pending_placements.size() != 0) begin
         $display("%0t ns: responses missing, expected %0d more, actual 0",
                  $time, pending_placements.size());
         mismatches++;
      end

      $display("Sent %0d nodes in %0d finished graphs; %0d responses checked, %0d mismatches.",
               nodes_sent, graphs_planned, responses_seen, mismatches);
      $display("Covered fan-in limits, repeats, batch and node total saturation, long hold-off.");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #1_000_000;
      $display("Timeout after %0t ns with %0d responses pending.",
               $time, pending_placements.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
